// ===== sv/mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mpt_pkg: shared types and constants for the mru profile table
// Holds the transfer payload structs, the slot entry layout, the per-cell
// control bundle, the sequencer states and the register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

   localparam int unsigned HIT_SLOT_W  = 4;
   localparam int unsigned PERSIST_W   = 5;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [63:0] DEFAULT_MAP_LOW_RESET  = 64'h0407_0908_0D04_0506;
   localparam logic [15:0] DEFAULT_MAP_HIGH_RESET = 16'h0506;

   // register select taken from the 8-byte aligned address bit
   localparam logic CSR_DEFAULT_MAP_LOW  = 1'b0;
   localparam logic CSR_DEFAULT_MAP_HIGH = 1'b1;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_SAVE   = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [63:0] save_map_low;
      logic [15:0] save_map_high;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [HIT_SLOT_W-1:0] hit_slot;
      logic                  map_valid;
      logic [63:0]           out_map_low;
      logic [15:0]           out_map_high;
      logic [PERSIST_W-1:0]  persist_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] vendor;
      logic [15:0] product;
      logic [63:0] map_low;
      logic [15:0] map_high;
   } entry_type;

   typedef struct packed {
      logic        cmp_en;    // capture compare result in every cell
      logic        search_en; // nonzero vendor, a match is allowed
      logic [15:0] vendor;
      logic [15:0] product;
      logic        save_en;   // commit the move-to-front shift
      logic        any_hit;   // a match exists somewhere in the row
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/mpt_csr.sv =====
// ----------------------------------------------------------------------------
// mpt_csr: default map registers
// Two write/read registers behind the bus port holding the map returned on
// a lookup miss.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [mpt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mpt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mpt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output logic      [63:0]                     default_map_low,
   output logic      [15:0]                     default_map_high
);

   logic [63:0] map_low_ff;
   logic [63:0] map_low_in;
   logic [15:0] map_high_ff;
   logic [15:0] map_high_in;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[mpt_pkg::CSR_ADDR_W-1];

   always_comb begin
      map_low_in  = map_low_ff;
      map_high_in = map_high_ff;
      if (wr_en) begin
         case (reg_sel)
            mpt_pkg::CSR_DEFAULT_MAP_LOW:  map_low_in  = pwdata;
            mpt_pkg::CSR_DEFAULT_MAP_HIGH: map_high_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff  <= mpt_pkg::DEFAULT_MAP_LOW_RESET;
         map_high_ff <= mpt_pkg::DEFAULT_MAP_HIGH_RESET;
      end else begin
         map_low_ff  <= map_low_in;
         map_high_ff <= map_high_in;
      end
   end

   always_comb begin
      case (reg_sel)
         mpt_pkg::CSR_DEFAULT_MAP_LOW:  prdata = map_low_ff;
         mpt_pkg::CSR_DEFAULT_MAP_HIGH: prdata = {48'd0, map_high_ff};
         default:                       prdata = '0;
      endcase
   end

   assign default_map_low  = map_low_ff;
   assign default_map_high = map_high_ff;

endmodule

`default_nettype wire

// ===== sv/mpt_cell.sv =====
// ----------------------------------------------------------------------------
// mpt_cell: one slot of the profile row
// Holds one entry, compares it against the broadcast key and, on a save,
// takes its predecessor's entry when it lies at or above the promoted slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mpt_pkg::cell_ctl_type ctl,
   input  wire mpt_pkg::entry_type    prev_entry,
   input  wire logic                  seen_in,
   output mpt_pkg::entry_type         entry,
   output logic                       first_hit,
   output logic                       seen_out
);

   mpt_pkg::entry_type entry_ff;
   mpt_pkg::entry_type entry_in;
   logic               match_ff;
   logic               match_in;
   logic               shift;

   // first match wins, earlier cells pass down a found flag
   assign first_hit = match_ff & ~seen_in;
   assign seen_out  = match_ff | seen_in;

   // on a hit only the cells up to the matching one move, on a miss all move
   assign shift = ctl.save_en & (~seen_in | ~ctl.any_hit);

   always_comb begin
      match_in = match_ff;
      if (ctl.cmp_en) begin
         match_in = ctl.search_en & (entry_ff.vendor == ctl.vendor) &
                    (entry_ff.product == ctl.product);
      end
      entry_in = shift ? prev_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== sv/mru_profile_table.sv =====
// ----------------------------------------------------------------------------
// mru_profile_table: most-recently-used table of device button-map profiles
// Lookup returns the stored or default map for a device identity; save moves
// or inserts the profile at the front and reports the slots to persist.
// ----------------------------------------------------------------------------
// Each request goes from transfer to result in order: it is accepted and
// its key latched, then every cell of the slot row compares its own entry
// against the key, and then the first match is resolved along the row, the
// result is formed and, for a save, every affected cell takes its neighbor's
// entry in a single move-to-front shift. A new request is taken only once
// the result enters the output register, so no new request is taken while
// one is in flight; a stalled result holds the row in its final step until
// the output register frees. The slot row resets to empty (all identities
// zero), and a vendor of zero never matches and never saves. The default
// map lives in two registers at byte addresses 0 and 8.
// ----------------------------------------------------------------------------
`default_nettype none

module mru_profile_table #(
   parameter int unsigned SLOTS = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire mpt_pkg::req_type                req_data,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output mpt_pkg::rsp_type                     rsp_data,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [mpt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mpt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mpt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   mpt_pkg::state_type    state_ff;
   mpt_pkg::state_type    state_in;
   mpt_pkg::req_type      key_ff;
   mpt_pkg::req_type      key_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   mpt_pkg::rsp_type      rsp_data_ff;
   mpt_pkg::rsp_type      rsp_data_in;

   logic [63:0]           default_map_low;
   logic [15:0]           default_map_high;

   mpt_pkg::cell_ctl_type cell_ctl;
   mpt_pkg::entry_type    new_entry;
   mpt_pkg::entry_type    entry_w [SLOTS];
   logic [SLOTS-1:0]      first_hit;
   logic [SLOTS:0]        seen;

   logic                  req_xfer;
   logic                  out_free;
   logic                  commit;
   logic                  vendor_nz;
   logic                  is_save;
   logic [mpt_pkg::HIT_SLOT_W-1:0] hit_slot;
   logic [63:0]           hit_map_low;
   logic [15:0]           hit_map_high;

   // ------------------------------------------------------------------------
   // default map registers
   // ------------------------------------------------------------------------
   mpt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .default_map_low  (default_map_low),
      .default_map_high (default_map_high)
   );

   // ------------------------------------------------------------------------
   // handshake and sequencing
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != mpt_pkg::ST_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   // output register can take a result when empty or being drained
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign commit    = (state_ff == mpt_pkg::ST_UPDATE) & out_free;

   assign vendor_nz = (key_ff.vendor_id != 16'd0);
   assign is_save   = (key_ff.op == mpt_pkg::OP_SAVE);

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      case (state_ff)
         mpt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               key_in   = req_data;
               state_in = mpt_pkg::ST_MATCH;
            end
         end
         mpt_pkg::ST_MATCH: begin
            state_in = mpt_pkg::ST_UPDATE;
         end
         mpt_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = mpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // key needs no reset, it is only read after a transfer loads it
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // ------------------------------------------------------------------------
   // slot row: cell 0 takes the new profile, each cell i takes cell i-1
   // ------------------------------------------------------------------------
   assign new_entry.vendor   = key_ff.vendor_id;
   assign new_entry.product  = key_ff.product_id;
   assign new_entry.map_low  = key_ff.save_map_low;
   assign new_entry.map_high = key_ff.save_map_high;

   assign cell_ctl.cmp_en    = (state_ff == mpt_pkg::ST_MATCH);
   assign cell_ctl.search_en = vendor_nz;
   assign cell_ctl.vendor    = key_ff.vendor_id;
   assign cell_ctl.product   = key_ff.product_id;
   assign cell_ctl.save_en   = commit & is_save & vendor_nz;
   assign cell_ctl.any_hit   = seen[SLOTS];

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      mpt_pkg::entry_type prev_entry;
      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
      end else begin : g_link
         assign prev_entry = entry_w[i-1];
      end
      mpt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .prev_entry (prev_entry),
         .seen_in    (seen[i]),
         .entry      (entry_w[i]),
         .first_hit  (first_hit[i]),
         .seen_out   (seen[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // resolve the matching slot; at most one first_hit bit is set
   // ------------------------------------------------------------------------
   always_comb begin
      hit_slot     = '0;
      hit_map_low  = '0;
      hit_map_high = '0;
      for (int unsigned i = 0; i < SLOTS; i++) begin
         if (first_hit[i]) begin
            hit_slot     = hit_slot | mpt_pkg::HIT_SLOT_W'(i);
            hit_map_low  = hit_map_low | entry_w[i].map_low;
            hit_map_high = hit_map_high | entry_w[i].map_high;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result register, decouples the row from a stalled receiver
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_valid_in              = rsp_valid_ff & rsp_stall;
      if (commit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.hit           = seen[SLOTS];
         rsp_data_in.hit_slot      = hit_slot;
         rsp_data_in.map_valid     = ~is_save & vendor_nz;
         rsp_data_in.out_map_low   = '0;
         rsp_data_in.out_map_high  = '0;
         rsp_data_in.persist_count = '0;
         if (~is_save & vendor_nz) begin
            // lookup: stored map on a hit, default map on a miss
            rsp_data_in.out_map_low  = seen[SLOTS] ? hit_map_low : default_map_low;
            rsp_data_in.out_map_high = seen[SLOTS] ? hit_map_high : default_map_high;
         end
         if (is_save & vendor_nz) begin
            // save: slots 0..hit_slot changed on a hit, the whole row on a miss
            rsp_data_in.persist_count = seen[SLOTS] ?
               mpt_pkg::PERSIST_W'(hit_slot) + mpt_pkg::PERSIST_W'(1) :
               mpt_pkg::PERSIST_W'(SLOTS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_first_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_hit))
      else $error("more than one slot claims the first match");

   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == mpt_pkg::ST_IDLE))
      else $error("finished request did not produce a result");

   a_save_lands_front: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.save_en |=> (entry_w[0].vendor == $past(key_ff.vendor_id)) &&
                           (entry_w[0].product == $past(key_ff.product_id)))
      else $error("saved profile not at the front slot");

   a_persist_only_save: assert property (@(posedge clock) disable iff (reset)
      commit && !(is_save && vendor_nz) |=> rsp_data_ff.persist_count == '0)
      else $error("persist count set for a request that changed nothing");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mpt_pkg::ST_IDLE) |-> !req_xfer)
      else $error("request taken while a request is in flight");

endmodule

`default_nettype wire
